// ----- sv/sci_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment / cylinder intersect package
// Shared constants, register codes and small types for the intersect unit.
// ----------------------------------------------------------------------------
package sci_pkg;

    // Default coordinate format: signed Q15.16.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Width of the degeneracy threshold register.
    localparam int THR_W = 16;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes, in address order.
    typedef enum logic [2:0] {
        REG_KEEPOUT_ENABLE  = 3'd0,
        REG_AXIS_X          = 3'd1,
        REG_AXIS_Y          = 3'd2,
        REG_KEEPOUT_RADIUS  = 3'd3,
        REG_SLAB_BOTTOM     = 3'd4,
        REG_SLAB_TOP        = 3'd5,
        REG_TINY_THRESHOLD  = 3'd6
    } reg_index_t;

    // How a clipped ratio is formed: pinned low, pinned high, or divided.
    typedef enum logic [1:0] {
        RATIO_ZERO = 2'd0,
        RATIO_ONE  = 2'd1,
        RATIO_DIV  = 2'd2
    } ratio_mode_t;

    // Queue status seen by the front, the back and the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- sv/sci_div_pipe.sv -----
// ----------------------------------------------------------------------------
// Pipelined fraction divider
// Restoring division of num/den (num < den), one quotient bit per stage.
// ----------------------------------------------------------------------------
module sci_div_pipe
    import sci_pkg::*;
#(
    parameter int DW = 33,
    parameter int QB = 16
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] quo
);

    logic [DW-1:0] rem_reg [QB];
    logic [DW-1:0] den_reg [QB];
    logic [QB-1:0] quo_reg [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_step
            logic [DW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QB-1:0] quo_in;
            logic [DW:0]   rem_dbl;
            logic          take;
            logic [DW:0]   rem_sub;

            // Stage inputs come from the port or from the previous stage.
            if (k == 0) begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            // One restoring step: double, compare, subtract.
            assign rem_dbl = {rem_in, 1'b0};
            assign take    = (rem_dbl >= {1'b0, den_in});
            assign rem_sub = take ? (rem_dbl - {1'b0, den_in}) : rem_dbl;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_sub[DW-1:0];
                    den_reg[k] <= den_in;
                    quo_reg[k] <= {quo_in[QB-2:0], take};
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QB-1];

endmodule

// ----- sv/sci_queue.sv -----
// ----------------------------------------------------------------------------
// Front-to-back queue
// Small register FIFO that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module sci_queue
    import sci_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output queue_status_t    status
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

    assign dout         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (AW+1)'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ----- sv/sci_front.sv -----
// ----------------------------------------------------------------------------
// Intersect front end
// Takes segments, clips them to the height slab and finds the clip and
// nearest-point parameters through pipelined dividers.
// ----------------------------------------------------------------------------
module sci_front
    import sci_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [6*W-1:0]       in_data,
    input  logic                 keepout_enable,
    input  logic [W-1:0]         axis_x,
    input  logic [W-1:0]         axis_y,
    input  logic [W-1:0]         slab_bottom,
    input  logic [W-1:0]         slab_top,
    input  logic [THR_W-1:0]     tiny_threshold,
    input  queue_status_t        q_status,
    output logic                 q_push,
    output logic                 last_valid,
    output logic [F+4*W+5:0]     q_data
);

    localparam int SW    = W + 1;
    localparam int WW    = W + 2;
    localparam int PW    = 2 * W + 2;
    localparam int SQW   = 2 * W + 3;
    localparam int DOTW  = 2 * W + 4;
    localparam int DWL   = 2 * W + 2;
    localparam int TW    = F + 1;
    localparam int SIDEW = 9 + 4 * SW;

    logic f_adv;

    // ---------------- stage 1: differences ----------------
    logic signed [W-1:0]  fx, fy, fz, tx, ty, tz;
    logic signed [SW-1:0] dz_c, na_c, nb_c, p0x_c, p0y_c, dx_c, dy_c;

    assign fx = $signed(in_data[W-1:0]);
    assign fy = $signed(in_data[2*W-1:W]);
    assign fz = $signed(in_data[3*W-1:2*W]);
    assign tx = $signed(in_data[4*W-1:3*W]);
    assign ty = $signed(in_data[5*W-1:4*W]);
    assign tz = $signed(in_data[6*W-1:5*W]);

    assign dz_c  = $signed({tz[W-1], tz}) - $signed({fz[W-1], fz});
    assign na_c  = $signed({slab_bottom[W-1], slab_bottom}) - $signed({fz[W-1], fz});
    assign nb_c  = $signed({slab_top[W-1], slab_top}) - $signed({fz[W-1], fz});
    assign p0x_c = $signed({fx[W-1], fx}) - $signed({axis_x[W-1], axis_x});
    assign p0y_c = $signed({fy[W-1], fy}) - $signed({axis_y[W-1], axis_y});
    assign dx_c  = $signed({tx[W-1], tx}) - $signed({fx[W-1], fx});
    assign dy_c  = $signed({ty[W-1], ty}) - $signed({fy[W-1], fy});

    logic                 v1_reg;
    logic                 kill1_reg;
    logic signed [SW-1:0] dz1_reg, na1_reg, nb1_reg;
    logic signed [SW-1:0] p0x1_reg, p0y1_reg, dx1_reg, dy1_reg;

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            kill1_reg <= !keepout_enable;
            dz1_reg   <= dz_c;
            na1_reg   <= na_c;
            nb1_reg   <= nb_c;
            p0x1_reg  <= p0x_c;
            p0y1_reg  <= p0y_c;
            dx1_reg   <= dx_c;
            dy1_reg   <= dy_c;
        end
    end

    // ---------------- stage 2: slab classification and products ----------------
    logic                 dz_neg, level, band_out, empty;
    logic [SW-1:0]        magdz;
    logic signed [WW-1:0] na_n, nb_n, d_n;
    ratio_mode_t          ma_c, mb_c;

    assign dz_neg   = dz1_reg[SW-1];
    assign magdz    = dz_neg ? $unsigned(-dz1_reg) : $unsigned(dz1_reg);
    assign level    = (dz1_reg == '0) || (magdz < {{(SW-THR_W){1'b0}}, tiny_threshold});
    assign na_n     = dz_neg ? -$signed({na1_reg[SW-1], na1_reg})
                             :  $signed({na1_reg[SW-1], na1_reg});
    assign nb_n     = dz_neg ? -$signed({nb1_reg[SW-1], nb1_reg})
                             :  $signed({nb1_reg[SW-1], nb1_reg});
    assign d_n      = $signed({1'b0, magdz});
    assign empty    = ((na_n > d_n) && (nb_n > d_n)) || (na_n[WW-1] && nb_n[WW-1]);
    assign band_out = (!na1_reg[SW-1] && (na1_reg != '0)) || nb1_reg[SW-1];

    // Pin each slab ratio low or high, else divide.
    always_comb
    begin
        if (na_n[WW-1] || (na_n == '0))
            ma_c = RATIO_ZERO;
        else if (na_n >= d_n)
            ma_c = RATIO_ONE;
        else
            ma_c = RATIO_DIV;
        if (nb_n[WW-1] || (nb_n == '0))
            mb_c = RATIO_ZERO;
        else if (nb_n >= d_n)
            mb_c = RATIO_ONE;
        else
            mb_c = RATIO_DIV;
    end

    logic                 v2_reg;
    logic                 kill2_reg, level2_reg;
    ratio_mode_t          ma2_reg, mb2_reg;
    logic [SW-1:0]        numa2_reg, numb2_reg, den2_reg;
    logic signed [PW-1:0] dxdx2_reg, dydy2_reg, pxdx2_reg, pydy2_reg;
    logic signed [SW-1:0] p0x2_reg, p0y2_reg, dx2_reg, dy2_reg;

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            kill2_reg  <= kill1_reg || (level ? band_out : empty);
            level2_reg <= level;
            ma2_reg    <= ma_c;
            mb2_reg    <= mb_c;
            numa2_reg  <= na_n[SW-1:0];
            numb2_reg  <= nb_n[SW-1:0];
            den2_reg   <= magdz;
            dxdx2_reg  <= dx1_reg * dx1_reg;
            dydy2_reg  <= dy1_reg * dy1_reg;
            pxdx2_reg  <= p0x1_reg * dx1_reg;
            pydy2_reg  <= p0y1_reg * dy1_reg;
            p0x2_reg   <= p0x1_reg;
            p0y2_reg   <= p0y1_reg;
            dx2_reg    <= dx1_reg;
            dy2_reg    <= dy1_reg;
        end
    end

    // ---------------- plane length and projection ----------------
    logic signed [SQW-1:0]  sq, dot;
    logic signed [DOTW-1:0] tdot, sq_x;
    logic signed [SQW-1:0]  thr_s;
    logic                   big;
    ratio_mode_t            mt_c;

    assign sq    = $signed({dxdx2_reg[PW-1], dxdx2_reg}) + $signed({dydy2_reg[PW-1], dydy2_reg});
    assign dot   = $signed({pxdx2_reg[PW-1], pxdx2_reg}) + $signed({pydy2_reg[PW-1], pydy2_reg});
    assign tdot  = -$signed({dot[SQW-1], dot});
    assign sq_x  = $signed({sq[SQW-1], sq});
    assign thr_s = $signed({{(SQW-THR_W){1'b0}}, tiny_threshold});
    assign big   = (sq > thr_s);

    always_comb
    begin
        if (tdot[DOTW-1] || (tdot == '0))
            mt_c = RATIO_ZERO;
        else if (tdot >= sq_x)
            mt_c = RATIO_ONE;
        else
            mt_c = RATIO_DIV;
    end

    // ---------------- divider stages ----------------
    logic [F-1:0] qa, qb, qt;

    sci_div_pipe #(.DW(SW), .QB(F)) u_div_a (
        .clk (clk),
        .en  (f_adv),
        .num (numa2_reg),
        .den (den2_reg),
        .quo (qa)
    );

    sci_div_pipe #(.DW(SW), .QB(F)) u_div_b (
        .clk (clk),
        .en  (f_adv),
        .num (numb2_reg),
        .den (den2_reg),
        .quo (qb)
    );

    sci_div_pipe #(.DW(DWL), .QB(F)) u_div_t (
        .clk (clk),
        .en  (f_adv),
        .num (tdot[DWL-1:0]),
        .den (sq[DWL-1:0]),
        .quo (qt)
    );

    // Side data travels beside the dividers.
    logic [SIDEW-1:0] side_reg [F];
    logic [F-1:0]     dv_reg;
    logic [SIDEW-1:0] side_in;

    assign side_in = {kill2_reg, level2_reg, ma2_reg, mb2_reg, mt_c, big,
                      p0x2_reg, p0y2_reg, dx2_reg, dy2_reg};

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < F; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // Valid line for all front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            dv_reg <= '0;
        end
        else if (f_adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            dv_reg <= {dv_reg[F-2:0], v2_reg};
        end
    end

    // ---------------- parameter selection ----------------
    function automatic logic [TW-1:0] ratio_val(ratio_mode_t m, logic [F-1:0] q);
        logic [TW-1:0] r;
        case (m)
            RATIO_ZERO: r = '0;
            RATIO_ONE:  r = {1'b1, {F{1'b0}}};
            default:    r = {1'b0, q};
        endcase
        return r;
    endfunction

    logic [SIDEW-1:0] side_out;
    logic             kill_o, level_o, big_o;
    ratio_mode_t      ma_o, mb_o, mt_o;
    logic [4*SW-1:0]  plane_o;
    logic [TW-1:0]    ta, tb, tc, t_min, t_max, t_sel;

    assign side_out = side_reg[F-1];
    assign kill_o   = side_out[SIDEW-1];
    assign level_o  = side_out[SIDEW-2];
    assign ma_o     = ratio_mode_t'(side_out[SIDEW-3 -: 2]);
    assign mb_o     = ratio_mode_t'(side_out[SIDEW-5 -: 2]);
    assign mt_o     = ratio_mode_t'(side_out[SIDEW-7 -: 2]);
    assign big_o    = side_out[4*SW];
    assign plane_o  = side_out[4*SW-1:0];

    assign ta = ratio_val(ma_o, qa);
    assign tb = ratio_val(mb_o, qb);
    assign tc = ratio_val(mt_o, qt);

    // Clip window; clamp the nearest-point parameter into it, or use its start.
    always_comb
    begin
        if (level_o)
        begin
            t_min = '0;
            t_max = {1'b1, {F{1'b0}}};
        end
        else
        begin
            t_min = (ta < tb) ? ta : tb;
            t_max = (ta < tb) ? tb : ta;
        end
        if (!big_o)
            t_sel = t_min;
        else if (tc < t_min)
            t_sel = t_min;
        else if (tc > t_max)
            t_sel = t_max;
        else
            t_sel = tc;
    end

    // Hand-off to the queue.
    assign last_valid = dv_reg[F-1];
    assign f_adv      = !(dv_reg[F-1] && q_status.full);
    assign q_push     = dv_reg[F-1] && !q_status.full;
    assign q_data     = {kill_o, t_sel, plane_o};
    assign in_ready   = f_adv;

endmodule

// ----- sv/sci_back.sv -----
// ----------------------------------------------------------------------------
// Intersect back end
// Forms the nearest point from the chosen parameter and compares its squared
// distance to the axis with the squared radius.
// ----------------------------------------------------------------------------
module sci_back
    import sci_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  queue_status_t    q_status,
    input  logic [F+4*W+5:0] q_data,
    output logic             q_pop,
    input  logic [W-2:0]     radius,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_hit
);

    localparam int SW  = W + 1;
    localparam int TW  = F + 1;
    localparam int MW  = W + F + 3;
    localparam int NW  = W + 3;
    localparam int DSW = 2 * NW + 1;
    localparam int RRW = 2 * W - 2;
    localparam int RW  = F + 4 * W + 6;

    logic b_adv;

    // Unpack the queued record.
    logic                 kill_q;
    logic [TW-1:0]        t_q;
    logic signed [SW-1:0] p0x_q, p0y_q, dx_q, dy_q;

    assign kill_q = q_data[RW-1];
    assign t_q    = q_data[RW-2 -: TW];
    assign p0x_q  = $signed(q_data[4*SW-1 -: SW]);
    assign p0y_q  = $signed(q_data[3*SW-1 -: SW]);
    assign dx_q   = $signed(q_data[2*SW-1 -: SW]);
    assign dy_q   = $signed(q_data[SW-1:0]);

    assign b_adv = !out_valid || out_ready;
    assign q_pop = b_adv && !q_status.empty;

    // Stage 1: parameter times direction.
    logic                 v1_reg, kill1_reg;
    logic signed [SW-1:0] p0x1_reg, p0y1_reg;
    logic signed [MW-1:0] tdx1_reg, tdy1_reg;

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            kill1_reg <= kill_q;
            p0x1_reg  <= p0x_q;
            p0y1_reg  <= p0y_q;
            tdx1_reg  <= $signed({1'b0, t_q}) * dx_q;
            tdy1_reg  <= $signed({1'b0, t_q}) * dy_q;
        end
    end

    // Stage 2: nearest point, floored to coordinate steps.
    logic signed [MW-1:0] sx, sy;

    assign sx = $signed({{2{p0x1_reg[SW-1]}}, p0x1_reg, {F{1'b0}}}) + tdx1_reg;
    assign sy = $signed({{2{p0y1_reg[SW-1]}}, p0y1_reg, {F{1'b0}}}) + tdy1_reg;

    logic                 v2_reg, kill2_reg;
    logic signed [NW-1:0] nx2_reg, ny2_reg;
    logic [RRW-1:0]       rr2_reg;

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            kill2_reg <= kill1_reg;
            nx2_reg   <= $signed(sx[MW-1:F]);
            ny2_reg   <= $signed(sy[MW-1:F]);
            rr2_reg   <= radius * radius;
        end
    end

    // Stage 3: squares.
    logic                   v3_reg, kill3_reg;
    logic signed [2*NW-1:0] nxx3_reg, nyy3_reg;
    logic [RRW-1:0]         rr3_reg;

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            kill3_reg <= kill2_reg;
            nxx3_reg  <= nx2_reg * nx2_reg;
            nyy3_reg  <= ny2_reg * ny2_reg;
            rr3_reg   <= rr2_reg;
        end
    end

    // Distance compare; the boundary counts as inside.
    logic signed [DSW-1:0] dist_sq;
    logic signed [DSW-1:0] rr_x;
    logic                  hit_c;

    assign dist_sq = $signed({nxx3_reg[2*NW-1], nxx3_reg})
                   + $signed({nyy3_reg[2*NW-1], nyy3_reg});
    assign rr_x    = $signed({{(DSW-RRW){1'b0}}, rr3_reg});
    assign hit_c   = !kill3_reg && (dist_sq <= rr_x);

    logic out_valid_reg, out_hit_reg;

    always_ff @(posedge clk)
    begin
        if (b_adv)
            out_hit_reg <= hit_c;
    end

    // Stage valids and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (b_adv)
        begin
            v1_reg        <= q_pop;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;

endmodule

// ----- sv/segment_cylinder_intersect_unit.sv -----
// ----------------------------------------------------------------------------
// Segment / vertical cylinder intersect unit
// Reports whether a 3D segment enters a configured cylinder keep-out zone.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         one segment: from_x/y/z, to_x/y/z
// m_*       out        one result: hit
// APB       in/out     seven configuration registers
//
// One segment is taken every cycle while the front is not stalled by a full
// queue; results pass the one-bit-per-stage dividers in the front end.
// A four-entry queue separates front and back so each stalls on its own.
// Reset clears all control state and loads the register reset values; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module segment_cylinder_intersect_unit
    import sci_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int IN_W   = ((6 * COORD_WIDTH + 7) / 8) * 8,
    localparam int APB_W  = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int ASH    = (COORD_WIDTH > 32) ? 3 : 2,
    localparam int ADDR_W = ASH + 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    // from_x, from_y, from_z, to_x, to_y, to_z from the lowest bit up
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    // hit in bit 0
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int RW = F + 4 * W + 6;

    // ---------------- configuration registers ----------------
    logic             enable_reg;
    logic [W-1:0]     axis_x_reg, axis_y_reg;
    logic [W-2:0]     radius_reg;
    logic [W-1:0]     bottom_reg, top_reg;
    logic [THR_W-1:0] thr_reg;
    logic             cfg_wr;
    reg_index_t       reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_index_t'(paddr[ADDR_W-1:ASH]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            axis_x_reg <= '0;
            axis_y_reg <= '0;
            radius_reg <= '0;
            bottom_reg <= '0;
            top_reg    <= '0;
            thr_reg    <= THR_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_KEEPOUT_ENABLE:  enable_reg <= pwdata[0];
                REG_AXIS_X:          axis_x_reg <= pwdata[W-1:0];
                REG_AXIS_Y:          axis_y_reg <= pwdata[W-1:0];
                REG_KEEPOUT_RADIUS:  radius_reg <= pwdata[W-2:0];
                REG_SLAB_BOTTOM:     bottom_reg <= pwdata[W-1:0];
                REG_SLAB_TOP:        top_reg    <= pwdata[W-1:0];
                REG_TINY_THRESHOLD:  thr_reg    <= pwdata[THR_W-1:0];
                default:             ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_idx)
            REG_KEEPOUT_ENABLE:  prdata = APB_W'(enable_reg);
            REG_AXIS_X:          prdata = APB_W'(axis_x_reg);
            REG_AXIS_Y:          prdata = APB_W'(axis_y_reg);
            REG_KEEPOUT_RADIUS:  prdata = APB_W'(radius_reg);
            REG_SLAB_BOTTOM:     prdata = APB_W'(bottom_reg);
            REG_SLAB_TOP:        prdata = APB_W'(top_reg);
            REG_TINY_THRESHOLD:  prdata = APB_W'(thr_reg);
            default:             prdata = '0;
        endcase
    end

    // ---------------- front, queue, back ----------------
    queue_status_t q_status;
    logic          q_push, q_pop, front_last_valid;
    logic [RW-1:0] q_din, q_dout;
    logic          hit;

    sci_front #(.W(W), .F(F)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_data        (s_tdata[6*W-1:0]),
        .keepout_enable (enable_reg),
        .axis_x         (axis_x_reg),
        .axis_y         (axis_y_reg),
        .slab_bottom    (bottom_reg),
        .slab_top       (top_reg),
        .tiny_threshold (thr_reg),
        .q_status       (q_status),
        .q_push         (q_push),
        .last_valid     (front_last_valid),
        .q_data         (q_din)
    );

    sci_queue #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .din    (q_din),
        .pop    (q_pop),
        .dout   (q_dout),
        .status (q_status)
    );

    sci_back #(.W(W), .F(F)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (q_dout),
        .q_pop     (q_pop),
        .radius    (radius_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hit   (hit)
    );

    assign m_tdata = {7'b0, hit};

`ifndef SYNTHESIS
    // A finished front item that meets a full queue stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_last_valid && q_status.full) |=> front_last_valid)
        else $error("front item lost while queue full");

    // A stalled output never draws from the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !q_pop)
        else $error("queue popped while output stalled");

    // The queue is never full and empty at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");
`endif

endmodule
